[hdl/mda_pkg.sv]
// ----------------------------------------------------------------------------
// mda_pkg
// Shared widths, field codes and controller-to-datapath command type of the
// motion delta accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package mda_pkg;

  localparam int unsigned ACC_WIDTH_DEF = 32;
  localparam int unsigned DELTA_W       = 8;
  localparam int unsigned QUAL_W        = 8;
  localparam int unsigned SUM_OUT_W     = 32;
  localparam int unsigned MEAN_W        = 15;
  localparam int unsigned IN_TDATA_W    = 24;
  localparam int unsigned OUT_TDATA_W   = 80;

  localparam logic MODE_REPORT  = 1'b0;
  localparam logic MODE_READOUT = 1'b1;

  typedef struct packed {
    logic acc_en;     // add the accepted report into the sums
    logic start_div;  // snapshot sums, clear them, seed the divider
    logic div_step;   // one restoring division step
    logic load_out;   // move the finished readout into the output register
  } cmd_t;

endpackage

`default_nettype wire

[hdl/mda_ctrl.sv]
// ----------------------------------------------------------------------------
// mda_ctrl
// Sequencer: takes items, runs the divider for one step per quotient bit and
// hands the readout to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mda_ctrl
  import mda_pkg::*;
#(
  parameter int unsigned ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_tvalid_i,
  input  wire logic s_mode_i,
  output logic      s_tready_o,
  output logic      m_tvalid_o,
  input  wire logic m_tready_i,
  output cmd_t      cmd_o
);

  localparam int unsigned STEP_W = $clog2(ACC_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD
  } state_e;

  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                m_valid_q, m_valid_d;
  logic                s_take;
  logic                out_free;

  assign s_tready_o = (state_q == ST_IDLE);
  assign s_take     = s_tvalid_i && s_tready_o;
  assign out_free   = !m_valid_q || m_tready_i;
  assign m_tvalid_o = m_valid_q;

  always_comb begin
    state_d         = state_q;
    step_d          = step_q;
    cmd_o           = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_take) begin
          if (s_mode_i == MODE_READOUT) begin
            cmd_o.start_div = 1'b1;
            step_d          = STEP_W'(ACC_WIDTH - 1);
            state_d         = ST_DIV;
          end else begin
            cmd_o.acc_en = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == '0) begin
          state_d = ST_LOAD;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      m_valid_d = 1'b1;
    end else begin
      m_valid_d = m_valid_q && !m_tready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

`default_nettype wire

[hdl/mda_dp.sv]
// ----------------------------------------------------------------------------
// mda_dp
// Datapath: wrapping position, quality and motion sums, a restoring divider
// one quotient bit per step, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mda_dp
  import mda_pkg::*;
#(
  parameter int unsigned ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cmd_t                     cmd_i,
  input  wire logic signed [DELTA_W-1:0] delta_x_i,
  input  wire logic signed [DELTA_W-1:0] delta_y_i,
  input  wire logic [QUAL_W-1:0]        quality_i,
  output logic signed [SUM_OUT_W-1:0]   sum_x_o,
  output logic signed [SUM_OUT_W-1:0]   sum_y_o,
  output logic [MEAN_W-1:0]             mean_quality_o,
  output logic                          count_was_zero_o
);

  logic [ACC_WIDTH-1:0] px_q, px_d;
  logic [ACC_WIDTH-1:0] py_q, py_d;
  logic [ACC_WIDTH-1:0] qs_q, qs_d;
  logic [ACC_WIDTH-1:0] cnt_q, cnt_d;
  logic                 moved;

  logic [ACC_WIDTH-1:0] snap_x_q;
  logic [ACC_WIDTH-1:0] snap_y_q;
  logic [ACC_WIDTH-1:0] divisor_q;
  logic [ACC_WIDTH-1:0] quo_q;
  logic [ACC_WIDTH-1:0] rem_q;
  logic                 zero_q;
  logic [ACC_WIDTH:0]   trial;
  logic [ACC_WIDTH:0]   diff;

  logic [SUM_OUT_W-1:0] out_x;
  logic [SUM_OUT_W-1:0] out_y;
  logic [MEAN_W-1:0]    mean;

  assign px_d  = px_q + {{(ACC_WIDTH - DELTA_W){delta_x_i[DELTA_W-1]}}, delta_x_i};
  assign py_d  = py_q + {{(ACC_WIDTH - DELTA_W){delta_y_i[DELTA_W-1]}}, delta_y_i};
  assign qs_d  = qs_q + {{(ACC_WIDTH - QUAL_W){1'b0}}, quality_i};
  assign moved = (px_d != '0) || (py_d != '0);
  assign cnt_d = cnt_q + {{(ACC_WIDTH - 1){1'b0}}, moved};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q  <= '0;
      py_q  <= '0;
      qs_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.start_div) begin
      px_q  <= '0;
      py_q  <= '0;
      qs_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.acc_en) begin
      px_q  <= px_d;
      py_q  <= py_d;
      qs_q  <= qs_d;
      cnt_q <= cnt_d;
    end
  end

  assign trial = {rem_q, quo_q[ACC_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_div) begin
      snap_x_q  <= px_q;
      snap_y_q  <= py_q;
      divisor_q <= cnt_q;
      quo_q     <= qs_q;
      rem_q     <= '0;
      zero_q    <= (cnt_q == '0);
    end else if (cmd_i.div_step) begin
      if (!diff[ACC_WIDTH]) begin
        rem_q <= diff[ACC_WIDTH-1:0];
      end else begin
        rem_q <= trial[ACC_WIDTH-1:0];
      end
      quo_q <= {quo_q[ACC_WIDTH-2:0], !diff[ACC_WIDTH]};
    end
  end

  generate
    if (ACC_WIDTH >= SUM_OUT_W) begin : g_trunc
      assign out_x = snap_x_q[SUM_OUT_W-1:0];
      assign out_y = snap_y_q[SUM_OUT_W-1:0];
    end else begin : g_sext
      assign out_x = {{(SUM_OUT_W - ACC_WIDTH){snap_x_q[ACC_WIDTH-1]}}, snap_x_q};
      assign out_y = {{(SUM_OUT_W - ACC_WIDTH){snap_y_q[ACC_WIDTH-1]}}, snap_y_q};
    end
  endgenerate

  always_comb begin
    if (zero_q) begin
      mean = '0;
    end else if (|quo_q[ACC_WIDTH-1:MEAN_W]) begin
      mean = '1;
    end else begin
      mean = quo_q[MEAN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sum_x_o          <= out_x;
      sum_y_o          <= out_y;
      mean_quality_o   <= mean;
      count_was_zero_o <= zero_q;
    end
  end

endmodule

`default_nettype wire

[hdl/motion_delta_accumulator.sv]
// ----------------------------------------------------------------------------
// motion_delta_accumulator
// Accumulates optical-flow motion reports and returns position sums and the
// mean surface quality on readout.
// ----------------------------------------------------------------------------
// A motion report (tuser 0) is taken while the sequencer is idle, and reports
// may arrive on every cycle. A readout (tuser 1) snapshots and clears the sums,
// then runs a restoring divider that produces one quotient bit per cycle, and
// the input stays stalled until the readout result is moved into the output
// register. It stalls longer only if an earlier result still waits in the
// output register. The motion count advances on every report after which the
// accumulated position is nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_delta_accumulator
  import mda_pkg::*;
#(
  parameter int unsigned ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // delta_x [7:0], delta_y [15:8], quality [23:16]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // mode
  input  wire logic                   s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // sum_x [31:0], sum_y [63:32], mean_quality [78:64], zero pad [79]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // count_was_zero
  output logic                        m_axis_tuser_o
);

  cmd_t                        cmd;
  logic signed [SUM_OUT_W-1:0] sum_x;
  logic signed [SUM_OUT_W-1:0] sum_y;
  logic [MEAN_W-1:0]           mean_quality;

  mda_ctrl #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_mode_i   (s_axis_tuser_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .cmd_o      (cmd)
  );

  mda_dp #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .delta_x_i        (s_axis_tdata_i[7:0]),
    .delta_y_i        (s_axis_tdata_i[15:8]),
    .quality_i        (s_axis_tdata_i[23:16]),
    .sum_x_o          (sum_x),
    .sum_y_o          (sum_y),
    .mean_quality_o   (mean_quality),
    .count_was_zero_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {1'b0, mean_quality, sum_y, sum_x};

endmodule

`default_nettype wire

[bench/tb_motion_delta_accumulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motion_delta_accumulator
// Streams motion reports and readouts into the accumulator. Each readout
// result is checked field by field against a behavioral model of the sums,
// the motion count and the saturated mean quality. The sender idles in bursts
// and the receiver stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------

module tb_motion_delta_accumulator;
  import mda_pkg::*;

  localparam int unsigned ACC_W = ACC_WIDTH_DEF;
  localparam int unsigned MEAN_SAT = (1 << MEAN_W) - 1;

  typedef struct {
    logic [SUM_OUT_W-1:0] sum_x;
    logic [SUM_OUT_W-1:0] sum_y;
    logic [MEAN_W-1:0]    mean_quality;
    logic                 count_was_zero;
  } readout_t;

  typedef enum int unsigned {
    RX_ALWAYS,
    RX_COIN,
    RX_PATTERN,
    RX_SPARSE
  } rx_style_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   s_axis_tuser_i = MODE_REPORT;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;

  logic [ACC_W-1:0] pos_x_sum;
  logic [ACC_W-1:0] pos_y_sum;
  logic [ACC_W-1:0] qual_sum;
  logic [ACC_W-1:0] motion_cnt;
  readout_t         readout_q[$];

  int unsigned fail_count = 0;
  int unsigned burst_left = 0;
  bit          sender_gaps_on = 1'b1;
  int unsigned rx_hold_req = 0;

  always #1 clk_i = ~clk_i;

  motion_delta_accumulator #(
    .ACC_WIDTH(ACC_W)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  task automatic accumulate_motion(input logic mode, input logic [DELTA_W-1:0] dx,
                                   input logic [DELTA_W-1:0] dy,
                                   input logic [QUAL_W-1:0] qual);
    readout_t         r;
    logic [ACC_W-1:0] quot;
    if (mode == MODE_REPORT) begin
      pos_x_sum = pos_x_sum + {{(ACC_W-DELTA_W){dx[DELTA_W-1]}}, dx};
      pos_y_sum = pos_y_sum + {{(ACC_W-DELTA_W){dy[DELTA_W-1]}}, dy};
      qual_sum  = qual_sum + ACC_W'(qual);
      if (pos_x_sum != '0 || pos_y_sum != '0) begin
        motion_cnt = motion_cnt + ACC_W'(1);
      end
    end else begin
      r.sum_x = SUM_OUT_W'(longint'(signed'(pos_x_sum)));
      r.sum_y = SUM_OUT_W'(longint'(signed'(pos_y_sum)));
      r.mean_quality = '0;
      r.count_was_zero = 1'b1;
      if (motion_cnt != '0) begin
        quot = qual_sum / motion_cnt;
        r.mean_quality = (quot > MEAN_SAT) ? MEAN_W'(MEAN_SAT) : quot[MEAN_W-1:0];
        r.count_was_zero = 1'b0;
      end
      readout_q.push_back(r);
      pos_x_sum  = '0;
      pos_y_sum  = '0;
      qual_sum   = '0;
      motion_cnt = '0;
    end
  endtask

  task automatic send_motion_item(input logic mode, input logic [DELTA_W-1:0] dx,
                                  input logic [DELTA_W-1:0] dy,
                                  input logic [QUAL_W-1:0] qual);
    int unsigned gap;
    if (sender_gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 5);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {qual, dy, dx};
    s_axis_tuser_i  <= mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    accumulate_motion(mode, dx, dy, qual);
  endtask

  task automatic sender_idle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed_extremes();
    send_motion_item(MODE_READOUT, 8'h00, 8'h00, 8'h00);
    send_motion_item(MODE_REPORT, 8'h7f, 8'h80, 8'hff);
    send_motion_item(MODE_REPORT, 8'h7f, 8'h80, 8'hff);
    send_motion_item(MODE_REPORT, 8'h80, 8'h7f, 8'h00);
    send_motion_item(MODE_READOUT, 8'hff, 8'hff, 8'hff);
    // return to the origin: the count must not advance on the second report
    send_motion_item(MODE_REPORT, 8'd5, 8'd0, 8'd10);
    send_motion_item(MODE_REPORT, -8'sd5, 8'd0, 8'd20);
    send_motion_item(MODE_REPORT, 8'd0, 8'd0, 8'd30);
    send_motion_item(MODE_READOUT, 8'h55, 8'haa, 8'h0f);
    send_motion_item(MODE_REPORT, 8'd0, 8'd0, 8'd200);
    send_motion_item(MODE_READOUT, 8'haa, 8'h55, 8'hf0);
    send_motion_item(MODE_READOUT, 8'h00, 8'h00, 8'h00);
    send_motion_item(MODE_READOUT, 8'hff, 8'hff, 8'hff);
    send_motion_item(MODE_REPORT, 8'h80, 8'h80, 8'hff);
    send_motion_item(MODE_READOUT, 8'h00, 8'h00, 8'h00);
    send_motion_item(MODE_REPORT, 8'd0, 8'd1, 8'd0);
    send_motion_item(MODE_READOUT, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_mean_saturation();
    int unsigned n;
    // hold position at the origin so the quality sum grows while the count stays zero
    n = $urandom_range(140, 150);
    repeat (n) send_motion_item(MODE_REPORT, 8'd0, 8'd0, QUAL_W'($urandom_range(240, 255)));
    send_motion_item(MODE_REPORT, 8'd1, 8'd0, QUAL_W'($urandom));
    send_motion_item(MODE_READOUT, DELTA_W'($urandom), DELTA_W'($urandom), QUAL_W'($urandom));
  endtask

  task automatic test_output_backpressure();
    sender_gaps_on = 1'b0;
    rx_hold_req = 400;
    repeat (10) begin
      repeat (3) send_motion_item(MODE_REPORT, DELTA_W'($urandom), DELTA_W'($urandom),
                                  QUAL_W'($urandom));
      send_motion_item(MODE_READOUT, DELTA_W'($urandom), DELTA_W'($urandom), QUAL_W'($urandom));
    end
    sender_gaps_on = 1'b1;
  endtask

  task automatic test_random_sessions(input int unsigned n_items);
    int unsigned sent;
    int unsigned run_len;
    int unsigned shape;
    logic [DELTA_W-1:0] dx;
    logic [DELTA_W-1:0] dy;
    sent = 0;
    while (sent < n_items) begin
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
        run_len = $urandom_range(1, 6);
        repeat (run_len) send_motion_item(1'($urandom), DELTA_W'($urandom), DELTA_W'($urandom),
                                          QUAL_W'($urandom));
      end else begin
        run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        repeat (run_len) begin
          case (shape % 4)
            0: begin
              dx = DELTA_W'($urandom);
              dy = DELTA_W'($urandom);
            end
            1: begin
              dx = DELTA_W'($urandom_range(0, 6)) - 8'd3;
              dy = DELTA_W'($urandom_range(0, 6)) - 8'd3;
            end
            2: begin
              dx = DELTA_W'($urandom_range(0, 2)) - 8'd1;
              dy = '0;
            end
            default: begin
              dx = ($urandom_range(0, 1) == 0) ? '0 : DELTA_W'($urandom);
              dy = DELTA_W'($urandom_range(0, 2)) - 8'd1;
            end
          endcase
          send_motion_item(MODE_REPORT, dx, dy, QUAL_W'($urandom));
        end
        send_motion_item(MODE_READOUT, DELTA_W'($urandom), DELTA_W'($urandom), QUAL_W'($urandom));
        run_len++;
      end
      sent += run_len;
    end
  endtask

  initial begin : result_sink
    int unsigned hold_left;
    int unsigned phase_left;
    rx_style_e   style;
    hold_left = 0;
    phase_left = 0;
    style = RX_ALWAYS;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req != 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          style = rx_style_e'($urandom_range(0, 3));
          phase_left = $urandom_range(20, 120);
        end
        phase_left--;
        case (style)
          RX_ALWAYS:  m_axis_tready_i <= 1'b1;
          RX_COIN:    m_axis_tready_i <= 1'($urandom);
          RX_PATTERN: m_axis_tready_i <= (phase_left % 5) < 2;
          default:    m_axis_tready_i <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_result
    readout_t got;
    readout_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.sum_x = m_axis_tdata_o[31:0];
      got.sum_y = m_axis_tdata_o[63:32];
      got.mean_quality = m_axis_tdata_o[78:64];
      got.count_was_zero = m_axis_tuser_o;
      if (readout_q.size() == 0) begin
        $display("%0t: unexpected result sum_x=%h sum_y=%h mean=%0d zero=%b", $realtime,
                 got.sum_x, got.sum_y, got.mean_quality, got.count_was_zero);
        fail_count++;
      end else begin
        want = readout_q.pop_front();
        if (got.sum_x !== want.sum_x) begin
          $display("%0t: sum_x expected %h actual %h", $realtime, want.sum_x, got.sum_x);
          fail_count++;
        end
        if (got.sum_y !== want.sum_y) begin
          $display("%0t: sum_y expected %h actual %h", $realtime, want.sum_y, got.sum_y);
          fail_count++;
        end
        if (got.mean_quality !== want.mean_quality) begin
          $display("%0t: mean_quality expected %0d actual %0d", $realtime,
                   want.mean_quality, got.mean_quality);
          fail_count++;
        end
        if (got.count_was_zero !== want.count_was_zero) begin
          $display("%0t: count_was_zero expected %b actual %b", $realtime,
                   want.count_was_zero, got.count_was_zero);
          fail_count++;
        end
      end
    end
  end

  initial begin
    pos_x_sum  = '0;
    pos_y_sum  = '0;
    qual_sum   = '0;
    motion_cnt = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_mean_saturation();
    test_output_backpressure();
    test_random_sessions(460);
    sender_idle();
    while (readout_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
hdl/mda_pkg.sv
hdl/mda_ctrl.sv
hdl/mda_dp.sv
hdl/motion_delta_accumulator.sv
bench/tb_motion_delta_accumulator.sv
